// ----- rtl/h1tok_pkg.sv -----
// Shared types and constants for the Hessian 1 value tokenizer.
package h1tok_pkg;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  // token kinds
  localparam logic [4:0] K_NULL     = 5'd0;
  localparam logic [4:0] K_BOOL     = 5'd1;
  localparam logic [4:0] K_INT      = 5'd2;
  localparam logic [4:0] K_LONG     = 5'd3;
  localparam logic [4:0] K_DATE     = 5'd4;
  localparam logic [4:0] K_DOUBLE   = 5'd5;
  localparam logic [4:0] K_STRBYTE  = 5'd6;
  localparam logic [4:0] K_BINBYTE  = 5'd7;
  localparam logic [4:0] K_LIST     = 5'd8;
  localparam logic [4:0] K_MAP      = 5'd9;
  localparam logic [4:0] K_END      = 5'd10;
  localparam logic [4:0] K_LISTLEN  = 5'd11;
  localparam logic [4:0] K_TYPEBYTE = 5'd12;
  localparam logic [4:0] K_REPLY    = 5'd13;
  localparam logic [4:0] K_FAULT    = 5'd14;
  localparam logic [4:0] K_DONE     = 5'd15;
  localparam logic [4:0] K_ERROR    = 5'd16;

  // payload kinds
  localparam logic [1:0] PK_STRING = 2'd0;
  localparam logic [1:0] PK_BINARY = 2'd1;
  localparam logic [1:0] PK_TYPE   = 2'd2;

  // tag characters
  localparam logic [7:0] CH_NULL     = 8'h4E; // N
  localparam logic [7:0] CH_TRUE     = 8'h54; // T
  localparam logic [7:0] CH_FALSE    = 8'h46; // F
  localparam logic [7:0] CH_LIST     = 8'h56; // V
  localparam logic [7:0] CH_MAP      = 8'h4D; // M
  localparam logic [7:0] CH_END      = 8'h7A; // z
  localparam logic [7:0] CH_FAULT    = 8'h66; // f
  localparam logic [7:0] CH_INT      = 8'h49; // I
  localparam logic [7:0] CH_LONG     = 8'h4C; // L
  localparam logic [7:0] CH_DATE     = 8'h64; // d
  localparam logic [7:0] CH_DOUBLE   = 8'h44; // D
  localparam logic [7:0] CH_LISTLEN  = 8'h6C; // l
  localparam logic [7:0] CH_REPLY    = 8'h72; // r
  localparam logic [7:0] CH_STR_MID  = 8'h73; // s
  localparam logic [7:0] CH_STR_FIN  = 8'h53; // S
  localparam logic [7:0] CH_BIN_MID  = 8'h62; // b
  localparam logic [7:0] CH_BIN_FIN  = 8'h42; // B
  localparam logic [7:0] CH_TYPE     = 8'h74; // t

  typedef enum logic [3:0] {
    PH_TAG, PH_INT, PH_LONG, PH_DATE, PH_DOUBLE, PH_LISTLEN, PH_REPLY,
    PH_LEN_HI, PH_LEN_LO, PH_BODY, PH_CHUNK_TAG
  } phase_t;

  typedef struct packed {
    logic [4:0]  kind;
    logic [63:0] value;
    logic        char_end;
    logic        last;
  } token_t;

  typedef struct packed {
    logic [1:0] count;
    token_t     tok0;
    token_t     tok1;
  } dec_out_t;

endpackage

// ----- rtl/hessian1_value_tokenizer_unit.sv -----
// Top level of the Hessian 1 value tokenizer: input stage, decoder, token queue.
//
// Takes a Hessian 1 stream one byte per word and gives one word per token.
// Each byte is registered in an input stage, decoded combinationally against the
// tokenizer state, and its zero, one or two tokens are written into a
// four-entry token queue that drives the master side. A new byte is taken
// every cycle as long as the queue has room for two tokens, so the rate is
// one byte per cycle; the only byte that yields two tokens is the last data
// byte of a final string, binary or type chunk (data token, then done token).
// The tokenizer state (phase, length counter, UTF-8 continuation count, 64-bit
// number accumulator) changes only when a byte leaves the input stage. m_tdata
// carries the token payload, m_tuser the token kind and the UTF-8 character-end
// flag, and m_tlast marks the last token caused by one input byte. The first
// token of a byte passes through the input stage register and the token queue
// before it is offered on the master side.
module hessian1_value_tokenizer_unit
  import h1tok_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // [63:0] token_value
  output logic [7:0]  m_tuser,   // [4:0] token_kind, [5] char_end, [7:6] zero
  output logic        m_tlast    // run_last
);

  // input stage
  logic       in_valid;
  logic [7:0] in_byte;
  logic       advance;

  logic [QCntW-1:0] q_count;
  token_t           q_head;
  dec_out_t         dec;

  // room for the worst case of two tokens
  assign advance  = in_valid && (q_count <= QCntW'(QDepth - 2));
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) in_byte <= s_tdata;
  end

  h1tok_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .fire      (advance),
    .data_byte (in_byte),
    .dout      (dec)
  );

  logic [1:0] push_count;
  logic       pop;

  assign push_count = advance ? dec.count : 2'd0;
  assign pop        = m_tvalid && m_tready;

  h1tok_outq u_outq (
    .clk        (clk),
    .rst        (rst),
    .push_count (push_count),
    .push0      (dec.tok0),
    .push1      (dec.tok1),
    .pop        (pop),
    .head       (q_head),
    .count      (q_count)
  );

  assign m_tvalid = (q_count != '0);
  assign m_tdata  = q_head.value;
  assign m_tuser  = {2'b00, q_head.char_end, q_head.kind};
  assign m_tlast  = q_head.last;

  // queue never overfills
  a_q_bound: assert property (@(posedge clk) disable iff (rst)
    q_count <= QCntW'(QDepth))
    else $error("token queue overflow");

  // a two-token byte is always a data token followed by done
  a_pair: assert property (@(posedge clk) disable iff (rst)
    (advance && dec.count == 2'd2) |->
      (dec.tok0.kind == K_STRBYTE || dec.tok0.kind == K_TYPEBYTE ||
       dec.tok0.kind == K_BINBYTE) && !dec.tok0.last)
    else $error("bad token pair");

  // exactly the last token of a byte carries the run marker
  a_last: assert property (@(posedge clk) disable iff (rst)
    (advance && dec.count == 2'd1) |-> dec.tok0.last)
    else $error("single token missing last marker");

  // queue and input stage empty under reset
  a_reset: assert property (@(posedge clk)
    rst |=> (q_count == '0) && !in_valid)
    else $error("state not cleared by reset");

endmodule

// ----- rtl/h1tok_decode.sv -----
// Tokenizer state and per-byte decode: up to two tokens per byte.
module h1tok_decode
  import h1tok_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       fire,
  input  logic [7:0] data_byte,
  output dec_out_t   dout
);

  phase_t      phase, phase_next;
  logic [15:0] chunk_remaining, chunk_remaining_next;
  logic [1:0]  continuation_left, continuation_left_next;
  logic [63:0] number_accumulator, number_accumulator_next;
  logic [3:0]  bytes_left, bytes_left_next;
  logic        final_chunk, final_chunk_next;
  logic [1:0]  payload_kind, payload_kind_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase              <= PH_TAG;
      chunk_remaining    <= '0;
      continuation_left  <= '0;
      number_accumulator <= '0;
      bytes_left         <= '0;
      final_chunk        <= 1'b0;
      payload_kind       <= PK_STRING;
    end else if (fire) begin
      phase              <= phase_next;
      chunk_remaining    <= chunk_remaining_next;
      continuation_left  <= continuation_left_next;
      number_accumulator <= number_accumulator_next;
      bytes_left         <= bytes_left_next;
      final_chunk        <= final_chunk_next;
      payload_kind       <= payload_kind_next;
    end
  end

  logic [63:0] acc_shift;
  logic [3:0]  bl_dec;
  logic [15:0] cr_dec;
  logic [15:0] cr_lo;
  logic        text_kind;
  logic [7:0]  mid_ch, fin_ch;

  assign acc_shift = {number_accumulator[55:0], data_byte};
  assign bl_dec    = bytes_left - 4'd1;
  assign cr_dec    = chunk_remaining - 16'd1;
  assign cr_lo     = {chunk_remaining[15:8], data_byte};
  assign text_kind = (payload_kind == PK_STRING) || (payload_kind == PK_TYPE);
  assign mid_ch    = (payload_kind == PK_STRING) ? CH_STR_MID : CH_BIN_MID;
  assign fin_ch    = (payload_kind == PK_STRING) ? CH_STR_FIN : CH_BIN_FIN;

  logic [4:0]  k0, k1;
  logic [63:0] v0;
  logic        ce0;
  logic [1:0]  n;
  logic        ends;

  always_comb begin
    phase_next              = phase;
    chunk_remaining_next    = chunk_remaining;
    continuation_left_next  = continuation_left;
    number_accumulator_next = number_accumulator;
    bytes_left_next         = bytes_left;
    final_chunk_next        = final_chunk;
    payload_kind_next       = payload_kind;
    k0   = K_NULL;
    k1   = K_DONE;
    v0   = '0;
    ce0  = 1'b0;
    n    = 2'd0;
    ends = 1'b0;

    unique case (phase)
      PH_INT, PH_LONG, PH_DATE, PH_DOUBLE, PH_LISTLEN, PH_REPLY: begin
        number_accumulator_next = acc_shift;
        bytes_left_next         = bl_dec;
        if (bl_dec == 4'd0) begin
          unique case (phase)
            PH_INT:     k0 = K_INT;
            PH_LONG:    k0 = K_LONG;
            PH_DATE:    k0 = K_DATE;
            PH_DOUBLE:  k0 = K_DOUBLE;
            PH_LISTLEN: k0 = K_LISTLEN;
            default:    k0 = K_REPLY;
          endcase
          v0         = acc_shift;
          n          = 2'd1;
          phase_next = PH_TAG;
        end
      end
      PH_LEN_HI: begin
        chunk_remaining_next = {data_byte, 8'h00};
        phase_next           = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        chunk_remaining_next   = cr_lo;
        continuation_left_next = '0;
        if (cr_lo == 16'd0) begin
          if (final_chunk) begin
            k0         = K_DONE;
            v0         = {62'd0, payload_kind};
            n          = 2'd1;
            phase_next = PH_TAG;
          end else begin
            phase_next = PH_CHUNK_TAG;
          end
        end else begin
          phase_next = PH_BODY;
        end
      end
      PH_BODY: begin
        v0 = {56'd0, data_byte};
        n  = 2'd1;
        if (text_kind) begin
          if (continuation_left != 2'd0) begin
            continuation_left_next = continuation_left - 2'd1;
          end else begin
            chunk_remaining_next = cr_dec;
            if (data_byte[7]) begin
              // lead byte: number of continuation bytes owed
              if (data_byte[7:4] == 4'hF)      continuation_left_next = 2'd3;
              else if (data_byte[7:4] == 4'hE) continuation_left_next = 2'd2;
              else                             continuation_left_next = 2'd1;
            end
          end
          ends = (continuation_left_next == 2'd0);
          k0   = (payload_kind == PK_TYPE) ? K_TYPEBYTE : K_STRBYTE;
          ce0  = ends;
        end else begin
          chunk_remaining_next = cr_dec;
          ends = 1'b1;
          k0   = K_BINBYTE;
        end
        if (ends && (chunk_remaining_next == 16'd0)) begin
          if (final_chunk) begin
            n          = 2'd2;
            phase_next = PH_TAG;
          end else begin
            phase_next = PH_CHUNK_TAG;
          end
        end
      end
      PH_CHUNK_TAG: begin
        if (data_byte == mid_ch || data_byte == fin_ch) begin
          final_chunk_next       = (data_byte == fin_ch);
          chunk_remaining_next   = '0;
          continuation_left_next = '0;
          phase_next             = PH_LEN_HI;
        end else begin
          k0         = K_ERROR;
          v0         = {56'd0, data_byte};
          n          = 2'd1;
          phase_next = PH_TAG;
        end
      end
      default: begin
        phase_next = PH_TAG;
        unique case (data_byte)
          CH_NULL:  begin k0 = K_NULL;  n = 2'd1; end
          CH_TRUE:  begin k0 = K_BOOL;  v0 = 64'd1; n = 2'd1; end
          CH_FALSE: begin k0 = K_BOOL;  n = 2'd1; end
          CH_LIST:  begin k0 = K_LIST;  n = 2'd1; end
          CH_MAP:   begin k0 = K_MAP;   n = 2'd1; end
          CH_END:   begin k0 = K_END;   n = 2'd1; end
          CH_FAULT: begin k0 = K_FAULT; n = 2'd1; end
          CH_INT, CH_LONG, CH_DATE, CH_DOUBLE, CH_LISTLEN, CH_REPLY: begin
            number_accumulator_next = '0;
            unique case (data_byte)
              CH_INT:     begin phase_next = PH_INT;     bytes_left_next = 4'd4; end
              CH_LONG:    begin phase_next = PH_LONG;    bytes_left_next = 4'd8; end
              CH_DATE:    begin phase_next = PH_DATE;    bytes_left_next = 4'd8; end
              CH_DOUBLE:  begin phase_next = PH_DOUBLE;  bytes_left_next = 4'd8; end
              CH_LISTLEN: begin phase_next = PH_LISTLEN; bytes_left_next = 4'd4; end
              default:    begin phase_next = PH_REPLY;   bytes_left_next = 4'd2; end
            endcase
          end
          CH_STR_MID, CH_STR_FIN, CH_BIN_MID, CH_BIN_FIN, CH_TYPE: begin
            chunk_remaining_next   = '0;
            continuation_left_next = '0;
            phase_next             = PH_LEN_HI;
            final_chunk_next       = (data_byte != CH_STR_MID) && (data_byte != CH_BIN_MID);
            if (data_byte == CH_TYPE)
              payload_kind_next = PK_TYPE;
            else if (data_byte == CH_BIN_MID || data_byte == CH_BIN_FIN)
              payload_kind_next = PK_BINARY;
            else
              payload_kind_next = PK_STRING;
          end
          default: begin
            k0 = K_ERROR;
            v0 = {56'd0, data_byte};
            n  = 2'd1;
          end
        endcase
      end
    endcase
  end

  always_comb begin
    dout.count          = n;
    dout.tok0.kind      = k0;
    dout.tok0.value     = v0;
    dout.tok0.char_end  = ce0;
    dout.tok0.last      = (n == 2'd1);
    dout.tok1.kind      = k1;
    dout.tok1.value     = {62'd0, payload_kind};
    dout.tok1.char_end  = 1'b0;
    dout.tok1.last      = 1'b1;
  end

endmodule

// ----- rtl/h1tok_outq.sv -----
// Token queue: takes up to two tokens a cycle, hands out one.
module h1tok_outq
  import h1tok_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic [1:0]       push_count,
  input  token_t           push0,
  input  token_t           push1,
  input  logic             pop,
  output token_t           head,
  output logic [QCntW-1:0] count
);

  token_t           entries [QDepth];
  logic [QPtrW-1:0] wr_ptr, rd_ptr;
  logic [QPtrW-1:0] wr_ptr1;

  assign wr_ptr1 = wr_ptr + QPtrW'(1);
  assign head    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push_count != 2'd0) entries[wr_ptr] <= push0;
    if (push_count == 2'd2) entries[wr_ptr1] <= push1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + QPtrW'(push_count);
      if (pop) rd_ptr <= rd_ptr + QPtrW'(1);
      count <= count + QCntW'(push_count) - QCntW'(pop);
    end
  end

endmodule
